// ----- rtl/core/address_resolution_cache_aging_macros.svh -----
// ----------------------------------------------------------------------------
// Address resolution cache - assertion macros
// Shared property wrappers, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RESOLUTION_CACHE_AGING_MACROS_SVH
`define ADDRESS_RESOLUTION_CACHE_AGING_MACROS_SVH

// same-cycle implication
`define ARCA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ARCA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/arca_pkg.sv -----
// ----------------------------------------------------------------------------
// arca_pkg
// Types and constants of the address resolution cache.
// ----------------------------------------------------------------------------
package arca_pkg;

    localparam int SLOT_W = 4;

    localparam logic [15:0] LIFETIME_RESET = 16'd300;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] ip_address;
        logic [47:0] mac_address;
        logic [31:0] now_ticks;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [47:0]       mac_out;
        logic [SLOT_W-1:0] slot;
    } t_out;

    // one table record as stored in the entry memory
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } t_entry;

endpackage

// ----- rtl/core/arca_mem.sv -----
// ----------------------------------------------------------------------------
// arca_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arca_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  arca_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output arca_pkg::t_entry  o_rdata
);

    arca_pkg::t_entry r_mem [DEPTH];
    arca_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/arca_ctrl.sv -----
// ----------------------------------------------------------------------------
// arca_ctrl
// Request sequencer: walks the entry memory one record per cycle, ages and
// matches records, writes back on update and holds the result register.
// ----------------------------------------------------------------------------
module arca_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  arca_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output arca_pkg::t_out    o_out_data,
    input  logic [15:0]       i_lifetime,
    output logic              o_mem_we,
    output logic [IW-1:0]     o_mem_waddr,
    output arca_pkg::t_entry  o_mem_wdata,
    output logic [IW-1:0]     o_mem_raddr,
    input  arca_pkg::t_entry  i_mem_rdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state           r_state;
    arca_pkg::t_in    r_item;
    logic [IW-1:0]    r_idx;
    logic             r_have_free;
    logic [IW-1:0]    r_free_idx;
    logic [ENTRIES-1:0] r_valid;
    arca_pkg::t_out   r_res;
    arca_pkg::t_out   r_out;
    logic             r_out_valid;

    logic             ip_hit;
    logic [31:0]      age;
    logic             fresh;
    logic             last;
    logic [IW-1:0]    n_free_idx;
    logic             load_out;

    // read data always belongs to r_idx while scanning
    always_comb begin
        ip_hit     = r_valid[r_idx] && (i_mem_rdata.ip == r_item.ip_address);
        age        = r_item.now_ticks - i_mem_rdata.stamp;
        fresh      = age < {16'd0, i_lifetime};
        last       = (r_idx == LAST_IDX);
        if (r_have_free) begin
            n_free_idx = r_free_idx;
        end else if (!r_valid[r_idx]) begin
            n_free_idx = r_idx;
        end else begin
            n_free_idx = '0;
        end

        // result register takes the new result once the old one is gone
        load_out = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = '{ip: r_item.ip_address, mac: r_item.mac_address,
                        stamp: r_item.now_ticks};
        if (r_state == ST_SCAN && r_item.func == arca_pkg::FUNC_UPDATE) begin
            if (ip_hit) begin
                o_mem_we = 1'b1;
            end else if (last) begin
                o_mem_we    = 1'b1;
                o_mem_waddr = n_free_idx;
            end
        end

        // prefetch the next record; wrap to 0 keeps the address in range
        if (r_state == ST_SCAN && !last) begin
            o_mem_raddr = r_idx + 1'b1;
        end else begin
            o_mem_raddr = '0;
        end
    end

    // the only write lands on the scan's final cycle and the next scan starts
    // only after ST_DONE and ST_IDLE, so reads never overlap a pending write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_item      <= i_in_data;
                        r_idx       <= '0;
                        r_have_free <= 1'b0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_item.func == arca_pkg::FUNC_LOOKUP) begin
                        if (ip_hit && fresh) begin
                            r_res   <= '{found: 1'b1, mac_out: i_mem_rdata.mac,
                                         slot: arca_pkg::SLOT_W'(r_idx)};
                            r_state <= ST_DONE;
                        end else begin
                            if (ip_hit) begin
                                r_valid[r_idx] <= 1'b0;  // aged out
                            end
                            if (last) begin
                                r_res   <= '0;
                                r_state <= ST_DONE;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end else begin
                        if (ip_hit) begin
                            r_res   <= '{found: 1'b1, mac_out: 48'd0,
                                         slot: arca_pkg::SLOT_W'(r_idx)};
                            r_state <= ST_DONE;
                        end else begin
                            if (!r_have_free && !r_valid[r_idx]) begin
                                r_have_free <= 1'b1;
                                r_free_idx  <= r_idx;
                            end
                            if (last) begin
                                r_valid[n_free_idx] <= 1'b1;
                                r_res   <= '{found: 1'b0, mac_out: 48'd0,
                                             slot: arca_pkg::SLOT_W'(n_free_idx)};
                                r_state <= ST_DONE;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/address_resolution_cache_aging.sv -----
// ----------------------------------------------------------------------------
// address_resolution_cache_aging
// IP-to-MAC cache with per-entry aging, lookup and update requests.
// ----------------------------------------------------------------------------
// A request is accepted into the scan, which reads the records through the
// single read port of the entry memory, one record per cycle, the read of
// record 0 starting at the accepting edge; the result register is then
// loaded. A lookup ends early on its first fresh hit and an update on its
// first match. One request is in flight at a time; the input opens the
// cycle after the result is loaded into the output register, even if that
// result is still stalled. A new result waits in the sequencer while the
// previous one is still stalled. Valid bits sit in flip-flops and clear at
// reset, so the block is usable right out of reset with no clearing pass.
// The lifetime register can be written at any time the block is idle.
module address_resolution_cache_aging #(
    parameter int ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  arca_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output arca_pkg::t_out  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [15:0]     i_cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [15:0]       r_lifetime;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    arca_pkg::t_entry  mem_wdata;
    logic [IW-1:0]     mem_raddr;
    arca_pkg::t_entry  mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= arca_pkg::LIFETIME_RESET;
        end else if (i_cfg_valid) begin
            r_lifetime <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    arca_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_lifetime  (r_lifetime),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    arca_mem #(
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- rtl/core/arca_checker.sv -----
// ----------------------------------------------------------------------------
// arca_checker
// Port-level checks of the address resolution cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "address_resolution_cache_aging_macros.svh"

module arca_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input arca_pkg::t_out  o_out_data
);

    // a stalled result stays offered and unchanged
    `ARCA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ARCA_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // one request at a time: taking one closes the input for the scan
    `ARCA_ASSERT_NXT(a_one_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // only a lookup hit carries an address
    `ARCA_ASSERT_IMP(a_mac_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.mac_out == 48'd0)

endmodule

bind address_resolution_cache_aging arca_checker u_arca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
